// ----- hdl/hpat_pkg.sv -----
// Shared types and constants for the host presence aging table.
// Used by the controller, the datapath and the top level; no dependencies.
package hpat_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int OUT_CNT_W = 6;

    localparam logic [31:0] GUARD_RESET = 32'd30000;

    typedef enum logic [1:0] {
        KIND_PROBE = 2'd0,
        KIND_PURGE = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_COMMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic [31:0] host;
        logic [31:0] seen;
        logic [47:0] link;
        logic        has_link;
    } entry_t;

    typedef struct packed {
        logic load_in;
        logic scan;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } sts_t;

    function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+OUT_CNT_W-1:0] w;
        w = (CNT_W + OUT_CNT_W)'(c);
        if (w > (CNT_W + OUT_CNT_W)'({OUT_CNT_W{1'b1}})) begin
            return {OUT_CNT_W{1'b1}};
        end
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

// ----- hdl/host_presence_aging_table.sv -----
// Top level of the host presence aging table: controller plus datapath.
// Depends on hpat_pkg, hpat_ctrl and hpat_datapath.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    kind, host, responded, hw addr, time
//   m_        out        m_valid/m_ready    include, guard, address, flags, counts
//   cfg_      in         cfg_wr_en          guard time (32 bits)
//
// Each transaction walks all ENTRIES slots through the entry memory read port,
// one slot per cycle, then passes the drain state and commits into the result
// register; a new transaction is accepted only after the last has committed.
// Reset (aresetn low, synchronous) empties the table at once and sets the
// guard time to 30000; no clearing pass. A held result stalls only the
// commit of the following transaction, whose scan proceeds meanwhile.
module host_presence_aging_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [31:0]                    cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  logic [31:0]                    s_host_address,
    input  logic                           s_responded,
    input  logic [47:0]                    s_hardware_address,
    input  logic [31:0]                    s_current_time,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_include_res,
    output logic                           m_via_guard,
    output logic [47:0]                    m_known_address,
    output logic                           m_address_known,
    output logic                           m_newly_added,
    output logic                           m_table_full,
    output logic [hpat_pkg::OUT_CNT_W-1:0] m_removed_count,
    output logic [hpat_pkg::OUT_CNT_W-1:0] m_kept_count
);

    hpat_pkg::cmd_t cmd;
    hpat_pkg::sts_t sts;

    hpat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hpat_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_kind             (s_kind),
        .s_host_address     (s_host_address),
        .s_responded        (s_responded),
        .s_hardware_address (s_hardware_address),
        .s_current_time     (s_current_time),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_include_res      (m_include_res),
        .m_via_guard        (m_via_guard),
        .m_known_address    (m_known_address),
        .m_address_known    (m_address_known),
        .m_newly_added      (m_newly_added),
        .m_table_full       (m_table_full),
        .m_removed_count    (m_removed_count),
        .m_kept_count       (m_kept_count)
    );

`ifndef SYNTH
    // Commit must never overwrite a result still waiting downstream
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("commit while result register occupied");

    // An accepted transaction starts its scan on the next cycle
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (cmd.scan && !s_ready))
        else $error("scan did not start after accept");

    // Scanning and accepting are mutually exclusive
    a_no_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> !s_ready)
        else $error("input accepted during scan");

    // Guarded results are always included, and insert and full flags are exclusive
    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_via_guard || m_include_res) && !(m_newly_added && m_table_full)))
        else $error("inconsistent result flags");
`endif

endmodule

// ----- hdl/hpat_ctrl.sv -----
// Sequencing controller for the host presence aging table.
// Depends on hpat_pkg for the state enum and the command and status structs.
module hpat_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  hpat_pkg::sts_t sts,
    output hpat_pkg::cmd_t cmd
);

    hpat_pkg::state_t state_reg;
    hpat_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hpat_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hpat_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = hpat_pkg::ST_SCAN;
                end
            end
            hpat_pkg::ST_SCAN: begin
                if (sts.scan_last) begin
                    state_next = hpat_pkg::ST_DRAIN;
                end
            end
            hpat_pkg::ST_DRAIN: begin
                state_next = hpat_pkg::ST_COMMIT;
            end
            hpat_pkg::ST_COMMIT: begin
                if (sts.out_free) begin
                    state_next = hpat_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hpat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.load_in = 1'b0;
        cmd.scan    = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            hpat_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            hpat_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            hpat_pkg::ST_COMMIT: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/hpat_datapath.sv -----
// Datapath for the host presence aging table: entry memory, valid bits,
// scan evaluation, commit logic and the result register. Depends on hpat_pkg.
module hpat_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hpat_pkg::cmd_t                     cmd,
    output hpat_pkg::sts_t                     sts,
    input  logic                               cfg_wr_en,
    input  logic [31:0]                        cfg_wr_data,
    input  logic [1:0]                         s_kind,
    input  logic [31:0]                        s_host_address,
    input  logic                               s_responded,
    input  logic [47:0]                        s_hardware_address,
    input  logic [31:0]                        s_current_time,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_include_res,
    output logic                               m_via_guard,
    output logic [47:0]                        m_known_address,
    output logic                               m_address_known,
    output logic                               m_newly_added,
    output logic                               m_table_full,
    output logic [hpat_pkg::OUT_CNT_W-1:0]     m_removed_count,
    output logic [hpat_pkg::OUT_CNT_W-1:0]     m_kept_count
);

    localparam int IW = hpat_pkg::IDX_W;
    localparam int CW = hpat_pkg::CNT_W;
    localparam int OW = hpat_pkg::OUT_CNT_W;

    // Configuration
    logic [31:0] guard_reg;

    // Captured transaction
    hpat_pkg::kind_t kind_reg;
    logic [31:0]     host_reg;
    logic            resp_reg;
    logic [47:0]     hw_reg;
    logic [31:0]     now_reg;

    // Table storage
    hpat_pkg::entry_t            entry_mem_reg [hpat_pkg::ENTRIES];
    hpat_pkg::entry_t            rd_data_reg;
    logic [hpat_pkg::ENTRIES-1:0] valid_reg;

    // Scan state
    logic [IW-1:0] scan_idx_reg;
    logic [IW-1:0] chk_idx_reg;
    logic          chk_vld_reg;
    logic          found_reg;
    logic [IW-1:0] match_idx_reg;
    logic [31:0]   match_seen_reg;
    logic [47:0]   match_link_reg;
    logic          match_has_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic [CW-1:0] kept_reg;
    logic [CW-1:0] removed_reg;

    // Result register
    logic          m_valid_reg;
    logic          include_reg;
    logic          via_guard_reg;
    logic [47:0]   known_addr_reg;
    logic          addr_known_reg;
    logic          added_reg;
    logic          full_reg;
    logic [OW-1:0] removed_out_reg;
    logic [OW-1:0] kept_out_reg;

    // Scan evaluation
    logic        chk_valid;
    logic [31:0] chk_age;
    logic        chk_live;
    logic        hit;
    logic        free_hit;
    logic        purge_hit;
    logic        keep_hit;

    // Commit evaluation
    logic             hw_nz;
    logic [31:0]      match_age;
    logic             match_live;
    logic             wr_en;
    logic [IW-1:0]    wr_idx;
    hpat_pkg::entry_t wr_data;
    logic             ins_en;
    logic             clr_all;
    logic             res_include;
    logic             res_via_guard;
    logic [47:0]      res_addr;
    logic             res_known;
    logic             res_added;
    logic             res_full;
    logic [CW-1:0]    res_removed;
    logic [CW-1:0]    res_kept;

    assign sts.scan_last = (scan_idx_reg == IW'(hpat_pkg::ENTRIES - 1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_reg <= hpat_pkg::GUARD_RESET;
        end else if (cfg_wr_en) begin
            guard_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg <= hpat_pkg::kind_t'(s_kind);
            host_reg <= s_host_address;
            resp_reg <= s_responded;
            hw_reg   <= s_hardware_address;
            now_reg  <= s_current_time;
        end
    end

    // Entry memory: one write port used at commit, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem_reg[wr_idx] <= wr_data;
        end
        if (cmd.scan) begin
            rd_data_reg <= entry_mem_reg[scan_idx_reg];
        end
    end

    always_comb begin
        chk_valid = valid_reg[chk_idx_reg];
        chk_age   = now_reg - rd_data_reg.seen;
        chk_live  = chk_age < guard_reg;
        hit       = chk_vld_reg && chk_valid && (kind_reg == hpat_pkg::KIND_PROBE)
                    && (rd_data_reg.host == host_reg) && !found_reg;
        free_hit  = chk_vld_reg && !chk_valid && !free_found_reg;
        purge_hit = chk_vld_reg && chk_valid && (kind_reg == hpat_pkg::KIND_PURGE)
                    && !chk_live;
        keep_hit  = chk_vld_reg && chk_valid && !purge_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chk_vld_reg <= 1'b0;
        end else begin
            chk_vld_reg <= cmd.scan;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            kept_reg       <= '0;
            removed_reg    <= '0;
        end else begin
            if (cmd.scan) begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
                chk_idx_reg  <= scan_idx_reg;
            end
            if (hit) begin
                found_reg      <= 1'b1;
                match_idx_reg  <= chk_idx_reg;
                match_seen_reg <= rd_data_reg.seen;
                match_link_reg <= rd_data_reg.link;
                match_has_reg  <= rd_data_reg.has_link;
            end
            if (free_hit) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= chk_idx_reg;
            end
            if (keep_hit) begin
                kept_reg <= kept_reg + CW'(1);
            end
            if (purge_hit) begin
                removed_reg <= removed_reg + CW'(1);
            end
        end
    end

    always_comb begin
        hw_nz         = (hw_reg != 48'd0);
        match_age     = now_reg - match_seen_reg;
        match_live    = match_age < guard_reg;
        wr_en         = 1'b0;
        wr_idx        = match_idx_reg;
        wr_data       = '{host: host_reg, seen: now_reg, link: hw_reg, has_link: hw_nz};
        ins_en        = 1'b0;
        clr_all       = 1'b0;
        res_include   = 1'b0;
        res_via_guard = 1'b0;
        res_addr      = 48'd0;
        res_known     = 1'b0;
        res_added     = 1'b0;
        res_full      = 1'b0;
        res_removed   = '0;
        res_kept      = kept_reg;
        case (kind_reg)
            hpat_pkg::KIND_PROBE: begin
                if (resp_reg) begin
                    res_include = 1'b1;
                    res_addr    = hw_reg;
                    res_known   = hw_nz;
                    if (found_reg) begin
                        // keep the stored link address when none was seen
                        wr_en = cmd.commit;
                        if (!hw_nz) begin
                            wr_data.link     = match_link_reg;
                            wr_data.has_link = match_has_reg;
                        end
                    end else if (free_found_reg) begin
                        wr_en     = cmd.commit;
                        wr_idx    = free_idx_reg;
                        ins_en    = cmd.commit;
                        res_added = 1'b1;
                        res_kept  = kept_reg + CW'(1);
                    end else begin
                        res_full = 1'b1;
                    end
                end else if (found_reg && match_live) begin
                    res_include   = 1'b1;
                    res_via_guard = 1'b1;
                    if (match_has_reg) begin
                        res_addr  = match_link_reg;
                        res_known = 1'b1;
                    end
                end
            end
            hpat_pkg::KIND_PURGE: begin
                res_removed = removed_reg;
            end
            hpat_pkg::KIND_CLEAR: begin
                clr_all  = cmd.commit;
                res_kept = '0;
            end
            default: begin
                res_kept = kept_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clr_all) begin
            valid_reg <= '0;
        end else if (ins_en) begin
            valid_reg[free_idx_reg] <= 1'b1;
        end else if (purge_hit) begin
            valid_reg[chk_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            include_reg     <= res_include;
            via_guard_reg   <= res_via_guard;
            known_addr_reg  <= res_addr;
            addr_known_reg  <= res_known;
            added_reg       <= res_added;
            full_reg        <= res_full;
            removed_out_reg <= hpat_pkg::sat_count(res_removed);
            kept_out_reg    <= hpat_pkg::sat_count(res_kept);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_include_res   = include_reg;
    assign m_via_guard     = via_guard_reg;
    assign m_known_address = known_addr_reg;
    assign m_address_known = addr_known_reg;
    assign m_newly_added   = added_reg;
    assign m_table_full    = full_reg;
    assign m_removed_count = removed_out_reg;
    assign m_kept_count    = kept_out_reg;

endmodule

// ----- dv/tb_host_presence_aging_table.sv -----
// Self-checking bench for host_presence_aging_table: directed and random probe,
// purge and clear traffic scored field by field against a behavioral table.
// Depends on hpat_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_host_presence_aging_table;

    localparam logic [1:0] KIND_RESERVED = 2'd3;
    localparam int HOST_POOL   = 48;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 100;

    // receiver stall patterns
    localparam int RX_ALWAYS   = 0;
    localparam int RX_COIN     = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] host;
        logic        responded;
        logic [47:0] hw;
        logic [31:0] now;
    } probe_t;

    typedef struct packed {
        logic        incl;
        logic        guard;
        logic [47:0] addr;
        logic        known;
        logic        added;
        logic        full;
        logic [5:0]  removed;
        logic [5:0]  kept;
    } verdict_t;

    logic        aclk;
    logic        aresetn            = 1'b0;
    logic        cfg_wr_en          = 1'b0;
    logic [31:0] cfg_wr_data        = '0;
    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind             = '0;
    logic [31:0] s_host_address     = '0;
    logic        s_responded        = 1'b0;
    logic [47:0] s_hardware_address = '0;
    logic [31:0] s_current_time     = '0;
    logic        m_valid;
    logic        m_ready            = 1'b0;
    logic        m_include_res;
    logic        m_via_guard;
    logic [47:0] m_known_address;
    logic        m_address_known;
    logic        m_newly_added;
    logic        m_table_full;
    logic [hpat_pkg::OUT_CNT_W-1:0] m_removed_count;
    logic [hpat_pkg::OUT_CNT_W-1:0] m_kept_count;

    // shadow of the host table and the guard register
    logic        tbl_valid    [hpat_pkg::ENTRIES];
    logic [31:0] tbl_host     [hpat_pkg::ENTRIES];
    logic [31:0] tbl_seen     [hpat_pkg::ENTRIES];
    logic [47:0] tbl_link     [hpat_pkg::ENTRIES];
    logic        tbl_has_link [hpat_pkg::ENTRIES];
    logic [31:0] guard_copy;

    verdict_t    due_verdicts[$];
    logic [31:0] host_pool [HOST_POOL];
    logic [31:0] tick_now;
    logic        hold_request = 1'b0;
    int          burst_left   = 0;
    int          error_count  = 0;

    host_presence_aging_table u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_host_address     (s_host_address),
        .s_responded        (s_responded),
        .s_hardware_address (s_hardware_address),
        .s_current_time     (s_current_time),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_include_res      (m_include_res),
        .m_via_guard        (m_via_guard),
        .m_known_address    (m_known_address),
        .m_address_known    (m_address_known),
        .m_newly_added      (m_newly_added),
        .m_table_full       (m_table_full),
        .m_removed_count    (m_removed_count),
        .m_kept_count       (m_kept_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one transaction to the shadow table and return the result it must produce.
    function automatic verdict_t sweep_verdict(input probe_t p);
        verdict_t    v;
        int          i;
        int          hit;
        int          free_slot;
        int          live;
        int          dropped;
        logic [31:0] age;
        v = '0;
        hit = -1;
        free_slot = -1;
        live = 0;
        dropped = 0;
        if (p.kind == hpat_pkg::KIND_PROBE) begin
            // walk downward so the lowest index wins
            for (i = hpat_pkg::ENTRIES - 1; i >= 0; i--) begin
                if (tbl_valid[i] && tbl_host[i] == p.host) begin
                    hit = i;
                end
                if (!tbl_valid[i]) begin
                    free_slot = i;
                end
            end
            if (p.responded) begin
                v.incl  = 1'b1;
                v.addr  = p.hw;
                v.known = (p.hw != '0);
                if (hit >= 0) begin
                    tbl_seen[hit] = p.now;
                    if (p.hw != '0) begin
                        tbl_link[hit]     = p.hw;
                        tbl_has_link[hit] = 1'b1;
                    end
                end else if (free_slot >= 0) begin
                    tbl_valid[free_slot]    = 1'b1;
                    tbl_host[free_slot]     = p.host;
                    tbl_seen[free_slot]     = p.now;
                    tbl_link[free_slot]     = p.hw;
                    tbl_has_link[free_slot] = (p.hw != '0);
                    v.added = 1'b1;
                end else begin
                    v.full = 1'b1;
                end
            end else if (hit >= 0) begin
                age = p.now - tbl_seen[hit];
                if (age < guard_copy) begin
                    v.incl  = 1'b1;
                    v.guard = 1'b1;
                    if (tbl_has_link[hit]) begin
                        v.addr  = tbl_link[hit];
                        v.known = 1'b1;
                    end
                end
            end
        end else if (p.kind == hpat_pkg::KIND_PURGE) begin
            for (i = 0; i < hpat_pkg::ENTRIES; i++) begin
                if (tbl_valid[i]) begin
                    age = p.now - tbl_seen[i];
                    if (!(age < guard_copy)) begin
                        tbl_valid[i] = 1'b0;
                        dropped++;
                    end
                end
            end
        end else if (p.kind == hpat_pkg::KIND_CLEAR) begin
            for (i = 0; i < hpat_pkg::ENTRIES; i++) begin
                tbl_valid[i] = 1'b0;
            end
        end
        for (i = 0; i < hpat_pkg::ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                live++;
            end
        end
        v.removed = (dropped > 63) ? 6'd63 : 6'(dropped);
        v.kept    = (live > 63) ? 6'd63 : 6'(live);
        return v;
    endfunction

    function automatic probe_t make_item(input logic [1:0] kind, input logic [31:0] host,
                                         input logic responded, input logic [47:0] hw,
                                         input logic [31:0] now);
        probe_t p;
        p.kind      = kind;
        p.host      = host;
        p.responded = responded;
        p.hw        = hw;
        p.now       = now;
        return p;
    endfunction

    function automatic logic [47:0] random_link();
        logic [63:0] r;
        int          pick;
        pick = $urandom_range(0, 9);
        r = {$urandom(), $urandom()};
        if (pick < 2) begin
            return '0;
        end
        if (pick == 2) begin
            return '1;
        end
        return r[47:0];
    endfunction

    // Offer one transaction, idling between bursts, and record its result once accepted.
    task automatic send_item(input probe_t p);
        int gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 60);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        s_valid            <= 1'b1;
        s_kind             <= p.kind;
        s_host_address     <= p.host;
        s_responded        <= p.responded;
        s_hardware_address <= p.hw;
        s_current_time     <= p.now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due_verdicts.push_back(sweep_verdict(p));
        burst_left--;
    endtask

    // Drop valid and wait until every pending result has been taken.
    task automatic settle_block();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_guard(input logic [31:0] ticks);
        settle_block();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        guard_copy = ticks;
    endtask

    task automatic compare_field(input string name, input logic [47:0] want,
                                 input logic [47:0] got);
        if (got !== want) begin
            if (error_count < MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_verdicts.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("%0t: unexpected result transaction, expected none, actual kept=%0d",
                             $time, m_kept_count);
                end
                error_count++;
            end else begin
                want = due_verdicts.pop_front();
                compare_field("include_res",   48'(want.incl),    48'(m_include_res));
                compare_field("via_guard",     48'(want.guard),   48'(m_via_guard));
                compare_field("known_address", want.addr,         m_known_address);
                compare_field("address_known", 48'(want.known),   48'(m_address_known));
                compare_field("newly_added",   48'(want.added),   48'(m_newly_added));
                compare_field("table_full",    48'(want.full),    48'(m_table_full));
                compare_field("removed_count", 48'(want.removed), 48'(m_removed_count));
                compare_field("kept_count",    48'(want.kept),    48'(m_kept_count));
            end
        end
    end

    // Receiver: segments of different stall patterns, plus a long hold-off on request.
    initial begin : result_sink
        int seg_len;
        int mode;
        int held;
        int tick;
        tick = 0;
        forever begin
            mode = $urandom_range(RX_ALWAYS, RX_PERIODIC);
            seg_len = $urandom_range(30, 300);
            repeat (seg_len) begin
                @(posedge aclk);
                tick++;
                if (hold_request) begin
                    m_ready <= 1'b0;
                    held = 0;
                    while (held < HOLD_CYCLES) begin
                        @(posedge aclk);
                        held++;
                    end
                    hold_request <= 1'b0;
                end else begin
                    case (mode)
                        RX_ALWAYS: m_ready <= 1'b1;
                        RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                        RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                        default:   m_ready <= ((tick % 7) < 3);
                    endcase
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_host_presence_aging_table failed");
        $finish;
    end

    // Lookup, refresh, guard aging across the time wrap, purge, reserved kind and clear.
    task automatic test_directed_lookup();
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h0, 1'b1, 48'h0, 32'd0));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF,
                            32'hFFFF_FFFF));
        // guarded, but no link address stored yet
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h0, 1'b0, 48'hFFFF_FFFF_FFFF,
                            32'd100));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h0, 1'b1, 48'h1234_5678_9ABC,
                            32'd200));
        // zero link address must not replace the stored one
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h0, 1'b1, 48'h0, 32'd300));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h0, 1'b0, 48'h0, 32'd400));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h1234_5678, 1'b0, 48'h0, 32'd400));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'd29998));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'hFFFF_FFFF, 1'b0, 48'h0, 32'd29999));
        send_item(make_item(hpat_pkg::KIND_PURGE, 32'h0, 1'b0, 48'h0, 32'd30299));
        send_item(make_item(KIND_RESERVED, 32'hFFFF_FFFF, 1'b1, 48'hFFFF_FFFF_FFFF,
                            32'hFFFF_FFFF));
        send_item(make_item(hpat_pkg::KIND_CLEAR, 32'h0, 1'b0, 48'h0, 32'd0));
    endtask

    task automatic test_guard_extremes();
        write_guard(32'd0);
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'hA5A5_A5A5, 1'b1,
                            48'h0000_0000_0001, 32'd1000));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'hA5A5_A5A5, 1'b0, 48'h0, 32'd1000));
        send_item(make_item(hpat_pkg::KIND_PURGE, 32'h0, 1'b0, 48'h0, 32'd1000));
        write_guard(32'd1);
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h5A5A_5A5A, 1'b1,
                            48'h8000_0000_0000, 32'd5000));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h5A5A_5A5A, 1'b0, 48'h0, 32'd5000));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h5A5A_5A5A, 1'b0, 48'h0, 32'd5001));
        send_item(make_item(hpat_pkg::KIND_PURGE, 32'h0, 1'b0, 48'h0, 32'd5001));
        write_guard(32'hFFFF_FFFF);
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h0F0F_0F0F, 1'b1, 48'h0, 32'd0));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h0F0F_0F0F, 1'b0, 48'h0,
                            32'hFFFF_FFFF));
        send_item(make_item(hpat_pkg::KIND_PROBE, 32'h0F0F_0F0F, 1'b0, 48'h0,
                            32'hFFFF_FFFE));
        send_item(make_item(hpat_pkg::KIND_PURGE, 32'h0, 1'b0, 48'h0, 32'hFFFF_FFFF));
    endtask

    // Hold the result side off while more new hosts arrive than the table holds.
    task automatic test_backpressure();
        int          k;
        logic [31:0] base;
        base = $urandom();
        send_item(make_item(hpat_pkg::KIND_CLEAR, 32'h0, 1'b0, 48'h0, tick_now));
        hold_request <= 1'b1;
        for (k = 0; k < hpat_pkg::ENTRIES + 8; k++) begin
            send_item(make_item(hpat_pkg::KIND_PROBE, base + k, 1'b1, random_link(),
                                tick_now + k));
        end
    endtask

    // Sweeps over a host pool: mostly probes with advancing time, some purges and
    // clears, a few reserved kinds and stray hosts at random times.
    task automatic run_sweeps(input int count);
        probe_t      p;
        int          n;
        int          roll;
        logic [31:0] stride;
        stride = (guard_copy >= 64) ? (guard_copy >> 5) : 32'd1;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            tick_now = tick_now + $urandom_range(0, stride);
            p = make_item(hpat_pkg::KIND_PROBE, host_pool[$urandom_range(0, HOST_POOL - 1)],
                          ($urandom_range(0, 99) < 55), random_link(), tick_now);
            if (roll < 7) begin
                p.kind = hpat_pkg::KIND_PURGE;
            end else if (roll < 8) begin
                p.kind = hpat_pkg::KIND_CLEAR;
            end else if (roll < 10) begin
                p.kind = KIND_RESERVED;
            end else if (roll < 16) begin
                p.host = $urandom();
                p.now  = $urandom();
            end
            send_item(p);
        end
    endtask

    task automatic test_random_sweeps();
        int k;
        host_pool[0] = 32'h0;
        host_pool[1] = 32'hFFFF_FFFF;
        for (k = 2; k < HOST_POOL; k++) begin
            host_pool[k] = $urandom();
        end
        write_guard(32'd30000);
        run_sweeps(118);
        write_guard(32'd1);
        run_sweeps(118);
        write_guard(32'hFFFF_FFFF);
        run_sweeps(118);
        write_guard(32'd0);
        run_sweeps(118);
        write_guard($urandom_range(2, 100000));
        run_sweeps(118);
        write_guard($urandom());
        run_sweeps(118);
    endtask

    initial begin
        int i;
        for (i = 0; i < hpat_pkg::ENTRIES; i++) begin
            tbl_valid[i]    = 1'b0;
            tbl_host[i]     = '0;
            tbl_seen[i]     = '0;
            tbl_link[i]     = '0;
            tbl_has_link[i] = 1'b0;
        end
        guard_copy = hpat_pkg::GUARD_RESET;
        tick_now = 32'hFFFF_F000;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_lookup();
        test_guard_extremes();
        test_backpressure();
        test_random_sweeps();
        settle_block();
        repeat (hpat_pkg::ENTRIES + 3) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_host_presence_aging_table passed");
        end else begin
            $display("tb_host_presence_aging_table failed");
        end
        $finish;
    end

endmodule

// ----- host_presence_aging_table.f -----
hdl/hpat_pkg.sv
hdl/hpat_ctrl.sv
hdl/hpat_datapath.sv
hdl/host_presence_aging_table.sv
dv/tb_host_presence_aging_table.sv
